### rtl/clfa_pkg.sv
package clfa_pkg;

    localparam int INODE_SLOTS_DEF = 128;
    localparam int TOTAL_PAGES_DEF = 131072;
    localparam int PAGE_BYTES_DEF  = 2048;

    localparam int IN_DW  = 88;
    localparam int OUT_DW = 72;
    localparam int ROW_W  = 17;

    typedef enum logic [2:0] {
        ACT_FORMAT = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_WRITE  = 3'd2,
        ACT_CLOSE  = 3'd3,
        ACT_OPEN   = 3'd4,
        ACT_READ   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FMT   = 3'd1,
        ST_OFFSET    = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_PAGE_FAIL = 3'd4,
        ST_EOF       = 3'd5
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
        logic step2;
        logic step3;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic long_op;
        logic open_op;
        logic out_free;
    } t_sts;

endpackage

### rtl/clfa_ram.sv
module clfa_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/clfa_ctrl.sv
module clfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  clfa_pkg::t_sts i_sts,
    output clfa_pkg::t_cmd o_cmd
);
    import clfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_STEP2 = 5'b00100,
        S_STEP3 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.long_op ? S_STEP2 : S_DONE;
            end
            S_STEP2: begin
                n_state = i_sts.open_op ? S_STEP3 : S_DONE;
            end
            S_STEP3: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.step2 = (r_state == S_STEP2);
    assign o_cmd.step3 = (r_state == S_STEP3);
    assign o_cmd.push  = (r_state == S_DONE) && i_sts.out_free;

endmodule

### rtl/clfa_dp.sv
module clfa_dp #(
    parameter int INODE_SLOTS = clfa_pkg::INODE_SLOTS_DEF,
    parameter int TOTAL_PAGES = clfa_pkg::TOTAL_PAGES_DEF,
    parameter int PAGE_BYTES  = clfa_pkg::PAGE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  clfa_pkg::t_cmd              i_cmd,
    output clfa_pkg::t_sts              o_sts,
    input  logic [2:0]                  i_action,
    input  logic [clfa_pkg::IN_DW-1:0]  i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [clfa_pkg::OUT_DW-1:0] o_data
);
    import clfa_pkg::*;

    localparam int AW = $clog2(INODE_SLOTS);
    localparam int PW = $clog2(TOTAL_PAGES);
    localparam int EW = PW + 1;

    // input word
    t_action     r_act;
    logic        r_force;
    logic [15:0] r_len;
    logic        r_ok;
    logic [31:0] r_off;

    // metadata state
    logic                   r_fmt;
    logic [AW-1:0]          r_head;
    logic [PW-1:0]          r_cur;
    logic [EW-1:0]          r_end;
    logic [31:0]            r_hb;
    logic [INODE_SLOTS-1:0] r_sv;
    logic [INODE_SLOTS-1:0] r_lv;
    logic [AW-1:0]          r_nx;
    logic                   r_svq;
    logic                   r_lvq;

    // result and output word
    t_status            r_status;
    logic [PW-1:0]      r_row;
    logic [15:0]        r_rlen;
    logic               r_save;
    logic               r_ovld;
    logic [OUT_DW-1:0]  r_odata;

    logic              len_big;
    logic              off_ok;
    logic [AW:0]       ix_t;
    logic [AW:0]       ix_s;
    logic [AW-1:0]     ix;
    logic [AW:0]       nx_s;
    logic [AW-1:0]     nx;
    logic [AW:0]       hn_s;
    logic [AW-1:0]     hn;
    logic [EW-1:0]     cur_inc;
    logic              cur_wrap;
    logic [PW-1:0]     cur_adv;
    logic [EW-1:0]     end_wrap;
    logic [AW-1:0]     raddr;
    logic [PW-1:0]     s_rdata;
    logic [31:0]       l_rdata;
    logic [PW-1:0]     start_q;
    logic [31:0]       len_q;
    logic              fmt_clear;
    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [PW-1:0]     s_wdata;
    logic              l_we;
    logic [ROW_W+PW-1:0] row_ext;

    assign len_big = r_len > 16'(PAGE_BYTES);
    assign off_ok  = r_off < 32'(INODE_SLOTS);

    // slot lying back_offset+1 before the head
    assign ix_t = (AW+1)'(INODE_SLOTS - 1) - {1'b0, r_off[AW-1:0]};
    assign ix_s = {1'b0, r_head} + ix_t;
    assign ix   = (ix_s >= (AW+1)'(INODE_SLOTS)) ?
                  AW'(ix_s - (AW+1)'(INODE_SLOTS)) : ix_s[AW-1:0];
    assign nx_s = {1'b0, ix} + (AW+1)'(1);
    assign nx   = (nx_s >= (AW+1)'(INODE_SLOTS)) ? '0 : nx_s[AW-1:0];
    assign hn_s = {1'b0, r_head} + (AW+1)'(1);
    assign hn   = (hn_s >= (AW+1)'(INODE_SLOTS)) ? '0 : hn_s[AW-1:0];

    // cursor advance, skipping the super block page on wrap
    assign cur_inc  = {1'b0, r_cur} + EW'(1);
    assign cur_wrap = cur_inc >= EW'(TOTAL_PAGES);
    assign cur_adv  = cur_wrap ? PW'(1) : cur_inc[PW-1:0];
    assign end_wrap = (r_end >= EW'(TOTAL_PAGES)) ? r_end - EW'(TOTAL_PAGES) : '0;

    assign start_q = r_svq ? s_rdata : '0;
    assign len_q   = r_lvq ? l_rdata : '0;

    assign raddr = i_cmd.step2 ? r_nx : ((r_act == ACT_OPEN) ? ix : r_head);

    assign fmt_clear = (r_act == ACT_FORMAT) && r_ok && (!r_fmt || r_force);
    assign s_we    = i_cmd.exec && (fmt_clear || r_act == ACT_CLOSE);
    assign s_waddr = fmt_clear ? '0 : hn;
    assign s_wdata = fmt_clear ? PW'(1) : r_cur;
    assign l_we    = i_cmd.exec && (r_act == ACT_CLOSE);

    clfa_ram #(.W(PW), .D(INODE_SLOTS)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (raddr),
        .o_rdata (s_rdata)
    );

    clfa_ram #(.W(32), .D(INODE_SLOTS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (r_head),
        .i_wdata (r_hb),
        .i_raddr (raddr),
        .o_rdata (l_rdata)
    );

    assign o_sts.open_op  = r_fmt && (r_act == ACT_OPEN) && off_ok;
    assign o_sts.long_op  = (r_fmt && (r_act == ACT_CREATE)) || o_sts.open_op;
    assign o_sts.out_free = !r_ovld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= 1'b0;
            r_head <= '0;
            r_cur  <= '0;
            r_end  <= '0;
            r_hb   <= '0;
            r_sv   <= '0;
            r_lv   <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_svq <= r_sv[raddr];
            r_lvq <= r_lv[raddr];

            if (i_cmd.load) begin
                r_act   <= t_action'(i_action);
                r_force <= i_data[0];
                r_len   <= i_data[48:33];
                r_ok    <= i_data[49];
                r_off   <= i_data[81:50];
            end

            if (i_cmd.exec) begin
                r_status <= ST_OK;
                r_row    <= '0;
                r_rlen   <= '0;
                r_save   <= 1'b0;
                unique case (r_act)
                    ACT_FORMAT: begin
                        if (!r_ok) begin
                            r_status <= ST_PAGE_FAIL;
                        end else if (fmt_clear) begin
                            r_sv    <= '0;
                            r_sv[0] <= 1'b1;
                            r_lv    <= '0;
                            r_head  <= '0;
                            r_fmt   <= 1'b1;
                            r_save  <= 1'b1;
                        end
                    end
                    ACT_CREATE: begin
                        if (!r_fmt) r_status <= ST_NOT_FMT;
                    end
                    ACT_WRITE: begin
                        if (len_big) begin
                            r_status <= ST_TOO_LONG;
                        end else begin
                            r_row <= r_cur;
                            if (!r_ok) begin
                                r_status <= ST_PAGE_FAIL;
                            end else begin
                                r_hb  <= r_hb + 32'(r_len);
                                r_cur <= cur_adv;
                            end
                        end
                    end
                    ACT_CLOSE: begin
                        r_lv[r_head] <= 1'b1;
                        r_lv[hn]     <= 1'b0;
                        r_sv[hn]     <= 1'b1;
                        r_head       <= hn;
                        r_save       <= 1'b1;
                    end
                    ACT_OPEN: begin
                        if (!r_fmt) begin
                            r_status <= ST_NOT_FMT;
                        end else if (!off_ok) begin
                            r_status <= ST_OFFSET;
                        end else begin
                            r_nx <= nx;
                        end
                    end
                    ACT_READ: begin
                        if ({1'b0, r_cur} >= r_end) begin
                            r_status <= ST_EOF;
                        end else if (len_big) begin
                            r_status <= ST_TOO_LONG;
                        end else begin
                            r_row <= r_cur;
                            if (!r_ok) begin
                                r_status <= ST_PAGE_FAIL;
                            end else begin
                                r_rlen <= r_len;
                                r_hb   <= r_hb - 32'(r_len);
                                r_cur  <= cur_adv;
                                if (cur_wrap) r_end <= end_wrap;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.step2) begin
                r_cur <= start_q;
                r_hb  <= (r_act == ACT_OPEN) ? len_q : '0;
            end

            // end of file is the start of the next slot, unwrapped past the ring end
            if (i_cmd.step3) begin
                r_end <= (r_cur >= start_q) ? {1'b0, start_q} + EW'(TOTAL_PAGES)
                                            : {1'b0, start_q};
            end

            if (r_ovld && i_ready) r_ovld <= 1'b0;
            if (i_cmd.push) begin
                r_ovld  <= 1'b1;
                r_odata <= {3'b000, r_save, r_hb, r_rlen, row_ext[ROW_W-1:0], r_status};
            end
        end
    end

    assign row_ext = {{ROW_W{1'b0}}, r_row};
    assign o_valid = r_ovld;
    assign o_data  = r_odata;

endmodule

### rtl/circular_log_file_allocator_unit.sv
// Flow: every item runs an execute step, then waits in done for a free output;
// a new item is taken only after that. A create on a formatted store adds a
// second step, and an open that passes its checks a second and third, for the
// registered slot RAM reads (open reads the start RAM at the slot and its successor).
// Reset: synchronous, active low; clears the flags, cursor, head and the per-slot
// valid bits at once, so the slot RAMs read as zero with no clearing pass.
module circular_log_file_allocator_unit #(
    parameter int INODE_SLOTS = clfa_pkg::INODE_SLOTS_DEF,
    parameter int TOTAL_PAGES = clfa_pkg::TOTAL_PAGES_DEF,
    parameter int PAGE_BYTES  = clfa_pkg::PAGE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // force_req[0], file_id[32:1], data_length[48:33], page_ok[49], back_offset[81:50]
    input  logic [clfa_pkg::IN_DW-1:0]  i_s_tdata,
    // action[2:0]
    input  logic [2:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // status[2:0], page_row[19:3], rd_bytes[35:20], file_bytes[67:36], save_super[68]
    output logic [clfa_pkg::OUT_DW-1:0] o_m_tdata
);
    import clfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    clfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    clfa_dp #(
        .INODE_SLOTS (INODE_SLOTS),
        .TOTAL_PAGES (TOTAL_PAGES),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_action (i_s_tuser),
        .i_data   (i_s_tdata),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in flight");

    a_save_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[68]) |-> (o_m_tdata[2:0] == ST_OK))
        else $error("super block save with error status");

    a_rlen_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[35:20] != 16'd0) |-> (o_m_tdata[2:0] == ST_OK))
        else $error("read length on failed item");

    a_row_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[19:3] != 17'd0) |->
        (o_m_tdata[2:0] == ST_OK || o_m_tdata[2:0] == ST_PAGE_FAIL))
        else $error("page row given with unexpected status");

endmodule
